// ===== design/bgr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgr_pkg
// Shared codes, widths and types of the bitmap glyph renderer.
// ----------------------------------------------------------------------------
package bgr_pkg;

  // Width of the font addresses and glyph offsets on the command port.
  localparam int ADDR_IN_W = 12;

  // Command codes.
  localparam logic [1:0] CMD_LOAD_DESC = 2'd0;
  localparam logic [1:0] CMD_LOAD_BYTE = 2'd1;
  localparam logic [1:0] CMD_DRAW      = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FIRST_CODE  = 2'd0;
  localparam logic [1:0] CFG_LAST_CODE   = 2'd1;
  localparam logic [1:0] CFG_SPACE_WIDTH = 2'd2;

  // Result kinds.
  localparam logic KIND_ROW    = 1'b0;
  localparam logic KIND_CURSOR = 1'b1;

  localparam logic [7:0] SPACE_CODE = 8'd32;

  // Request to the address reduction unit.
  typedef struct packed {
    logic                 go;
    logic [ADDR_IN_W-1:0] value;
  } red_req_t;

endpackage

// ===== design/bitmap_glyph_renderer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_glyph_renderer
// Proportional bitmap font renderer: descriptor and font loads, glyph drawing.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. A descriptor load is
// written when it is taken and leaves the block idle. A font byte load waits
// for the STEPS compare-and-subtract passes of the address reduction unit (one
// pass at the default font size) and then writes the byte. A space or an
// out-of-range code leaves the block idle and gives the cursor result in the
// next cycle. A drawn glyph reads its descriptor, reduces its offset and then
// fetches n bytes for each of its h rows (n = min(ceil(w / 8), 4), n = 0 for a
// zero-width glyph): the font memory gives one byte per cycle, so its single
// read port sets the row time. Results leave on the out_ ports for exactly
// one cycle each, marked by out_valid, and the receiver cannot stall them: the
// rows of a drawn glyph are followed in order by one cursor transfer that
// carries out_last. Both the glyph table and the font memory hold anything
// until written, and no clearing pass runs after reset.
// ----------------------------------------------------------------------------
module bitmap_glyph_renderer #(
  parameter int GLYPH_COUNT      = 128,
  parameter int FONT_BYTES       = 4096,
  parameter int MAX_GLYPH_WIDTH  = 32,
  parameter int MAX_GLYPH_HEIGHT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // Command channel.
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [6:0]  in_glyph_index,
  input  logic [5:0]  in_glyph_width,
  input  logic [5:0]  in_glyph_height,
  input  logic [11:0] in_glyph_offset,
  input  logic [11:0] in_font_address,
  input  logic [7:0]  in_font_byte,
  input  logic [7:0]  in_char_code,
  input  logic [15:0] in_pos_x,
  input  logic [15:0] in_pos_y,
  // Result channel.
  output logic        out_valid,
  output logic        out_kind,
  output logic [15:0] out_x,
  output logic [15:0] out_y,
  output logic [31:0] out_row_mask,
  output logic        out_last,
  // Configuration channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import bgr_pkg::*;

  localparam int TI_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int FA_W = $clog2(FONT_BYTES);
  localparam int WW   = $clog2(MAX_GLYPH_WIDTH + 1);
  localparam int HW   = $clog2(MAX_GLYPH_HEIGHT + 1);

  typedef struct packed {
    logic [WW-1:0]        w;
    logic [HW-1:0]        h;
    logic [ADDR_IN_W-1:0] off;
  } desc_t;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_RED_LOAD = 7'b0000010,
    ST_DESC     = 7'b0000100,
    ST_RED_OFF  = 7'b0001000,
    ST_ROW      = 7'b0010000,
    ST_LASTB    = 7'b0100000,
    ST_CURSOR   = 7'b1000000
  } state_t;

  function automatic logic [7:0] bit_rev(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7 - i];
    end
    return r;
  endfunction

  state_t state_r, state_nxt;

  logic [7:0] first_code_r, last_code_r, space_width_r;

  logic [15:0]     px_r, px_nxt, py_r, py_nxt;
  logic [WW-1:0]   w_r, w_nxt;
  logic [HW-1:0]   h_r, h_nxt;
  logic [HW-1:0]   row_r, row_nxt;
  logic [3:0]      stride_r, stride_nxt;
  logic [2:0]      nb_r, nb_nxt;
  logic [2:0]      j_r, j_nxt;
  logic [FA_W-1:0] base_r, base_nxt;
  logic [7:0]      byte_r, byte_nxt;
  logic [31:0]     mask_r, mask_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r, out_kind_nxt;
  logic [15:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic [31:0] out_mask_r, out_mask_nxt;
  logic        out_last_r, out_last_nxt;

  // Memories.
  desc_t           tab_mem [GLYPH_COUNT];
  desc_t           tab_rd_r;
  logic            tab_we, tab_re;
  logic [TI_W-1:0] tab_waddr, tab_raddr;
  desc_t           tab_wdata;
  logic [7:0]      font_mem [FONT_BYTES];
  logic [7:0]      font_rd_r;
  logic            font_we, font_re;
  logic [FA_W-1:0] font_raddr;

  // Address reduction unit.
  red_req_t        red_req;
  logic            red_done;
  logic [FA_W-1:0] red_result;

  // Decode of the command port.
  logic       accept;
  logic [8:0] gidx_ext;
  logic [6:0] w_in_ext, h_in_ext;
  logic [6:0] w_sat, h_sat;
  logic [7:0] code_idx;
  logic [8:0] code_idx_ext;
  logic       in_range;

  // Glyph walk arithmetic.
  logic [WW:0]     w_plus7;
  logic [3:0]      stride_new;
  logic [FA_W:0]   byte_sum, base_sum;
  logic [FA_W-1:0] byte_addr, base_wrap;
  logic [2:0]      j_prev;
  logic [31:0]     placed;
  logic [63:0]     wmask_wide;
  logic [HW-1:0]   row_inc;

  assign accept = start && !busy;

  assign gidx_ext  = 9'(in_glyph_index);
  assign w_in_ext  = 7'(in_glyph_width);
  assign h_in_ext  = 7'(in_glyph_height);
  assign w_sat     = (w_in_ext > 7'(MAX_GLYPH_WIDTH)) ? 7'(MAX_GLYPH_WIDTH) : w_in_ext;
  assign h_sat     = (h_in_ext > 7'(MAX_GLYPH_HEIGHT)) ? 7'(MAX_GLYPH_HEIGHT) : h_in_ext;
  assign tab_waddr = gidx_ext[TI_W-1:0];
  assign tab_wdata = '{w: w_sat[WW-1:0], h: h_sat[HW-1:0], off: in_glyph_offset};
  assign tab_we    = accept && (in_command == CMD_LOAD_DESC) &&
                     (gidx_ext < 9'(GLYPH_COUNT));

  // Table index of the requested code; both bounds and the table size count.
  assign code_idx     = in_char_code - first_code_r;
  assign code_idx_ext = 9'(code_idx);
  assign in_range     = (in_char_code >= first_code_r) && (in_char_code <= last_code_r) &&
                        (code_idx_ext < 9'(GLYPH_COUNT));
  assign tab_raddr    = code_idx_ext[TI_W-1:0];

  // Bytes per row from the stored width; a zero-width glyph still steps by one.
  assign w_plus7    = (WW + 1)'(tab_rd_r.w) + (WW + 1)'(7);
  assign stride_new = (tab_rd_r.w == '0) ? 4'd1 : 4'(w_plus7 >> 3);

  // Row base plus byte index, and row base plus stride, each wrap at most once.
  assign byte_sum  = (FA_W + 1)'(base_r) + (FA_W + 1)'(j_r[1:0]);
  assign byte_addr = (byte_sum >= (FA_W + 1)'(FONT_BYTES)) ?
                     FA_W'(byte_sum - (FA_W + 1)'(FONT_BYTES)) : byte_sum[FA_W-1:0];
  assign base_sum  = (FA_W + 1)'(base_r) + (FA_W + 1)'(stride_r);
  assign base_wrap = (base_sum >= (FA_W + 1)'(FONT_BYTES)) ?
                     FA_W'(base_sum - (FA_W + 1)'(FONT_BYTES)) : base_sum[FA_W-1:0];

  // The byte read in the previous cycle lands MSB-first at bit 8 * (j - 1).
  assign j_prev     = j_r - 3'd1;
  assign placed     = 32'(bit_rev(font_rd_r)) << {j_prev[1:0], 3'b000};
  assign wmask_wide = (64'd1 << w_r) - 64'd1;
  assign row_inc    = row_r + HW'(1);

  always_comb begin
    state_nxt     = state_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    row_nxt       = row_r;
    stride_nxt    = stride_r;
    nb_nxt        = nb_r;
    j_nxt         = j_r;
    base_nxt      = base_r;
    byte_nxt      = byte_r;
    mask_nxt      = mask_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_mask_nxt  = out_mask_r;
    out_last_nxt  = out_last_r;
    red_req       = '{go: 1'b0, value: '0};
    tab_re        = 1'b0;
    font_we       = 1'b0;
    font_re       = 1'b0;
    font_raddr    = byte_addr;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_command)
            CMD_LOAD_BYTE: begin
              red_req   = '{go: 1'b1, value: in_font_address};
              byte_nxt  = in_font_byte;
              state_nxt = ST_RED_LOAD;
            end
            CMD_DRAW: begin
              px_nxt = in_pos_x;
              py_nxt = in_pos_y;
              if (in_char_code == SPACE_CODE) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_CURSOR;
                out_x_nxt     = in_pos_x + 16'(space_width_r) + 16'd2;
                out_y_nxt     = in_pos_y;
                out_mask_nxt  = '0;
                out_last_nxt  = 1'b1;
              end else if (!in_range) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_CURSOR;
                out_x_nxt     = in_pos_x;
                out_y_nxt     = in_pos_y;
                out_mask_nxt  = '0;
                out_last_nxt  = 1'b1;
              end else begin
                tab_re    = 1'b1;
                state_nxt = ST_DESC;
              end
            end
            default: begin
              // Descriptor loads are written by tab_we; the unused code is dropped.
            end
          endcase
        end
      end
      ST_RED_LOAD: begin
        if (red_done) begin
          font_we   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_DESC: begin
        w_nxt      = tab_rd_r.w;
        h_nxt      = tab_rd_r.h;
        stride_nxt = stride_new;
        nb_nxt     = (tab_rd_r.w == '0) ? 3'd0 :
                     (stride_new > 4'd4) ? 3'd4 : stride_new[2:0];
        red_req    = '{go: 1'b1, value: tab_rd_r.off};
        state_nxt  = ST_RED_OFF;
      end
      ST_RED_OFF: begin
        if (red_done) begin
          base_nxt  = red_result;
          row_nxt   = '0;
          j_nxt     = '0;
          mask_nxt  = '0;
          state_nxt = (h_r == '0) ? ST_CURSOR : ST_ROW;
        end
      end
      ST_ROW, ST_LASTB: begin
        if ((state_r == ST_ROW) && (nb_r != 3'd0)) begin
          // Fetch one byte of the row and fold in the one fetched before it.
          font_re = 1'b1;
          if (j_r != 3'd0) begin
            mask_nxt = mask_r | placed;
          end
          j_nxt = j_r + 3'd1;
          if (j_r == nb_r - 3'd1) begin
            state_nxt = ST_LASTB;
          end
        end else begin
          // Row complete: emit it and step to the next row or to the cursor.
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_ROW;
          out_x_nxt     = px_r + 16'd1;
          out_y_nxt     = py_r + 16'(row_r);
          out_mask_nxt  = (state_r == ST_LASTB) ? ((mask_r | placed) & wmask_wide[31:0]) : '0;
          out_last_nxt  = 1'b0;
          row_nxt       = row_inc;
          base_nxt      = base_wrap;
          j_nxt         = '0;
          mask_nxt      = '0;
          state_nxt     = (row_inc == h_r) ? ST_CURSOR : ST_ROW;
        end
      end
      ST_CURSOR: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_CURSOR;
        out_x_nxt     = px_r + 16'(w_r) + 16'd2;
        out_y_nxt     = py_r;
        out_mask_nxt  = '0;
        out_last_nxt  = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  bgr_addr_reduce #(
    .FONT_BYTES(FONT_BYTES)
  ) u_reduce (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (red_req),
    .done  (red_done),
    .result(red_result)
  );

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      first_code_r  <= 8'd32;
      last_code_r   <= 8'd126;
      space_width_r <= 8'd4;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FIRST_CODE:  first_code_r  <= cfg_data;
          CFG_LAST_CODE:   last_code_r   <= cfg_data;
          CFG_SPACE_WIDTH: space_width_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Working and result payload.
  always_ff @(posedge clk) begin
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    w_r        <= w_nxt;
    h_r        <= h_nxt;
    row_r      <= row_nxt;
    stride_r   <= stride_nxt;
    nb_r       <= nb_nxt;
    j_r        <= j_nxt;
    base_r     <= base_nxt;
    byte_r     <= byte_nxt;
    mask_r     <= mask_nxt;
    out_kind_r <= out_kind_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_mask_r <= out_mask_nxt;
    out_last_r <= out_last_nxt;
  end

  // Glyph descriptor table.
  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
    if (tab_re) begin
      tab_rd_r <= tab_mem[tab_raddr];
    end
  end

  // Font byte memory.
  always_ff @(posedge clk) begin
    if (font_we) begin
      font_mem[red_result] <= byte_r;
    end
    if (font_re) begin
      font_rd_r <= font_mem[font_raddr];
    end
  end

  assign busy         = (state_r != ST_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_x        = out_x_r;
  assign out_y        = out_y_r;
  assign out_row_mask = out_mask_r;
  assign out_last     = out_last_r;

`ifndef SYNTHESIS
  // A row transfer is always followed by more work, so the block stays busy.
  a_row_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == KIND_ROW)) |-> (state_r != ST_IDLE))
    else $error("row result shown while idle");

  // Only the cursor transfer closes a run.
  a_last_is_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_kind_r == KIND_CURSOR))
    else $error("last flag on a row result");

  // A space gives its cursor on the next cycle and leaves the block free.
  a_space_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_command == CMD_DRAW) && (in_char_code == SPACE_CODE))
    |=> (out_valid_r && (out_kind_r == KIND_CURSOR) && !busy))
    else $error("space did not give a single cursor result");

  // The font memory is only written when the reduced address arrives.
  a_font_write: assert property (@(posedge clk) disable iff (!rst_n)
    font_we |-> (red_done && (state_r == ST_RED_LOAD)))
    else $error("font write without a reduced address");
`endif

endmodule

// ===== design/bgr_addr_reduce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgr_addr_reduce
// Iterative reduction of a command-port address modulo the font size.
// ----------------------------------------------------------------------------
module bgr_addr_reduce #(
  parameter int FONT_BYTES = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bgr_pkg::red_req_t             req,
  output logic                          done,
  output logic [$clog2(FONT_BYTES)-1:0] result
);
  import bgr_pkg::*;

  localparam int FA_W   = $clog2(FONT_BYTES);
  localparam int RED_W  = (FA_W + 1 > 13) ? FA_W + 1 : 13;
  localparam int STEPS0 = $clog2((1 << ADDR_IN_W) / FONT_BYTES + 1);
  localparam int STEPS  = (STEPS0 < 1) ? 1 : STEPS0;
  localparam int K_W    = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [RED_W-1:0] val_r, val_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [RED_W-1:0] modulus;

  // One restoring step per cycle: subtract the modulus scaled by 2^k if it fits.
  assign modulus = RED_W'(FONT_BYTES) << k_r;

  always_comb begin
    val_nxt  = val_r;
    k_nxt    = k_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.go) begin
      val_nxt  = RED_W'(req.value);
      k_nxt    = K_W'(STEPS - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (val_r >= modulus) begin
        val_nxt = val_r - modulus;
      end
      if (k_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        k_nxt = k_r - K_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    k_r   <= k_nxt;
  end

  assign done   = done_r;
  assign result = val_r[FA_W-1:0];

endmodule

// ===== dv/tb_bitmap_glyph_renderer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_glyph_renderer
// Self-checking bench for the bitmap glyph renderer: descriptor and font byte
// loads, glyph, space and out-of-range draws under several code ranges, with
// every result compared against a bench-side rendering of the same commands.
// ----------------------------------------------------------------------------
module tb_bitmap_glyph_renderer;
  import bgr_pkg::*;

  localparam int GLYPH_COUNT      = 128;
  localparam int FONT_BYTES       = 4096;
  localparam int MAX_GLYPH_WIDTH  = 32;
  localparam int MAX_GLYPH_HEIGHT = 32;

  // Command code 3 is not assigned; the block must swallow it silently.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // These bounds are loose even for a full 32 by 32 glyph.
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 32;
  localparam int PRINT_CAP     = 50;

  typedef struct {
    logic [1:0]  command;
    logic [6:0]  glyph_index;
    logic [5:0]  glyph_width;
    logic [5:0]  glyph_height;
    logic [11:0] glyph_offset;
    logic [11:0] font_address;
    logic [7:0]  font_byte;
    logic [7:0]  char_code;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
  } glyph_cmd_t;

  typedef struct {
    logic        kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] row_mask;
    logic        last;
  } glyph_result_t;

  // --------------------------------------------------------------------------
  // Clock, reset and the block's ports. Every input is known from time zero.
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_command = '0;
  logic [6:0]  in_glyph_index = '0;
  logic [5:0]  in_glyph_width = '0;
  logic [5:0]  in_glyph_height = '0;
  logic [11:0] in_glyph_offset = '0;
  logic [11:0] in_font_address = '0;
  logic [7:0]  in_font_byte = '0;
  logic [7:0]  in_char_code = '0;
  logic [15:0] in_pos_x = '0;
  logic [15:0] in_pos_y = '0;
  logic        out_valid;
  logic        out_kind;
  logic [15:0] out_x;
  logic [15:0] out_y;
  logic [31:0] out_row_mask;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  always #6 clk = ~clk;

  bitmap_glyph_renderer #(
    .GLYPH_COUNT      (GLYPH_COUNT),
    .FONT_BYTES       (FONT_BYTES),
    .MAX_GLYPH_WIDTH  (MAX_GLYPH_WIDTH),
    .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_glyph_index  (in_glyph_index),
    .in_glyph_width  (in_glyph_width),
    .in_glyph_height (in_glyph_height),
    .in_glyph_offset (in_glyph_offset),
    .in_font_address (in_font_address),
    .in_font_byte    (in_font_byte),
    .in_char_code    (in_char_code),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_row_mask    (out_row_mask),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Bench state.
  // --------------------------------------------------------------------------
  int cycle_count = 0;
  int mismatch_count = 0;
  int queued_count = 0;
  int idle_pct = 18;

  glyph_cmd_t    pending_cmds[$];
  glyph_cmd_t    on_port;
  glyph_result_t rows_and_cursors[$];
  glyph_result_t seen;
  glyph_result_t due;

  // Code range and space advance as the block holds them. They only change
  // while the block is idle, so the stimulus planner reads them too.
  logic [7:0] cur_first = 8'd32;
  logic [7:0] cur_last  = 8'd126;
  logic [7:0] cur_space = 8'd4;

  // Rendering state: what the block's glyph table and font memory hold after
  // every accepted command.
  logic [5:0]  tbl_width  [GLYPH_COUNT];
  logic [5:0]  tbl_height [GLYPH_COUNT];
  logic [11:0] tbl_offset [GLYPH_COUNT];
  logic [7:0]  font_image [FONT_BYTES];

  // Planning state: what the table will hold once the queued commands are in,
  // and which entries and bytes have been written at all. Draws are only
  // planned when every entry and byte they read has been written.
  logic [5:0]  plan_width  [GLYPH_COUNT];
  logic [5:0]  plan_height [GLYPH_COUNT];
  logic [11:0] plan_offset [GLYPH_COUNT];
  bit          plan_desc_set [GLYPH_COUNT];
  bit          plan_byte_set [FONT_BYTES];

  // --------------------------------------------------------------------------
  // Glyph arithmetic shared by rendering and planning.
  // --------------------------------------------------------------------------
  function automatic logic [5:0] clamp_size(input logic [5:0] v, input int limit);
    return (int'(v) > limit) ? 6'(limit) : v;
  endfunction

  // Table slot of a code, or -1 when the code falls outside the glyph range.
  function automatic int glyph_slot(input logic [7:0] code);
    int c;
    int f;
    c = code;
    f = cur_first;
    if (c < f || c > int'(cur_last) || c - f >= GLYPH_COUNT) return -1;
    return c - f;
  endfunction

  // Font address of byte j of a given row. A zero-width glyph still has a
  // row stride of one byte.
  function automatic int glyph_byte_addr(input logic [11:0] off, input int j,
                                         input int row, input logic [5:0] w);
    int stride;
    stride = (w == 6'd0) ? 1 : (int'(w) + 7) / 8;
    return (int'(off) + j + row * stride) % FONT_BYTES;
  endfunction

  // --------------------------------------------------------------------------
  // Rendering of one accepted command into the results it must produce.
  // --------------------------------------------------------------------------
  function automatic void push_cursor(input logic [15:0] x, input logic [15:0] y);
    glyph_result_t r;
    r.kind     = KIND_CURSOR;
    r.x        = x;
    r.y        = y;
    r.row_mask = '0;
    r.last     = 1'b1;
    rows_and_cursors.push_back(r);
  endfunction

  function automatic void render_command(input glyph_cmd_t c);
    int            idx;
    int            a;
    logic [5:0]    w;
    logic [5:0]    h;
    logic [7:0]    b;
    glyph_result_t r;
    case (c.command)
      CMD_LOAD_DESC: begin
        if (int'(c.glyph_index) < GLYPH_COUNT) begin
          tbl_width[c.glyph_index]  = clamp_size(c.glyph_width, MAX_GLYPH_WIDTH);
          tbl_height[c.glyph_index] = clamp_size(c.glyph_height, MAX_GLYPH_HEIGHT);
          tbl_offset[c.glyph_index] = c.glyph_offset;
        end
      end
      CMD_LOAD_BYTE: begin
        font_image[int'(c.font_address) % FONT_BYTES] = c.font_byte;
      end
      CMD_DRAW: begin
        idx = glyph_slot(c.char_code);
        // The space test comes first, so a space draws nothing even when 32
        // lies inside the glyph range.
        if (c.char_code == SPACE_CODE) begin
          push_cursor(c.pos_x + 16'(cur_space) + 16'd2, c.pos_y);
        end else if (idx < 0) begin
          push_cursor(c.pos_x, c.pos_y);
        end else begin
          w = tbl_width[idx];
          h = tbl_height[idx];
          for (int row = 0; row < int'(h); row++) begin
            r.kind     = KIND_ROW;
            r.x        = c.pos_x + 16'd1;
            r.y        = c.pos_y + 16'(row);
            r.row_mask = '0;
            r.last     = 1'b0;
            // Pixel i comes from bit 7 - i%8 of byte i/8 of the row, so the
            // leftmost pixel of each byte lands in the lowest mask bit.
            for (int i = 0; i < int'(w) && i < 32; i++) begin
              a = glyph_byte_addr(tbl_offset[idx], i / 8, row, w);
              b = font_image[a];
              if (b[7 - (i % 8)]) r.row_mask[i] = 1'b1;
            end
            rows_and_cursors.push_back(r);
          end
          push_cursor(c.pos_x + 16'(w) + 16'd2, c.pos_y);
        end
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting. Printing stops after a while so that a badly broken
  // block cannot flood the log, but every mismatch is still counted.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
  endtask

  // --------------------------------------------------------------------------
  // Command driver. A transfer happens at an edge where start is high and
  // busy is low; the accepted command is rendered right there. When the port
  // is free the next queued command goes out, or start drops and the port idles.
  // start gets at most one assignment per edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) render_command(on_port);
      if (!start || !busy) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
          on_port = pending_cmds.pop_front();
          start           <= 1'b1;
          in_command      <= on_port.command;
          in_glyph_index  <= on_port.glyph_index;
          in_glyph_width  <= on_port.glyph_width;
          in_glyph_height <= on_port.glyph_height;
          in_glyph_offset <= on_port.glyph_offset;
          in_font_address <= on_port.font_address;
          in_font_byte    <= on_port.font_byte;
          in_char_code    <= on_port.char_code;
          in_pos_x        <= on_port.pos_x;
          in_pos_y        <= on_port.pos_y;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. Each out_valid cycle is one transfer that the bench cannot
  // refuse; it is matched field by field against the oldest expected result.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      seen.kind     = out_kind;
      seen.x        = out_x;
      seen.y        = out_y;
      seen.row_mask = out_row_mask;
      seen.last     = out_last;
      if (rows_and_cursors.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0b x=%h y=%h mask=%h last=%0b",
                                  seen.kind, seen.x, seen.y, seen.row_mask, seen.last));
      end else begin
        due = rows_and_cursors.pop_front();
        if (seen.kind !== due.kind || seen.x !== due.x || seen.y !== due.y ||
            seen.row_mask !== due.row_mask || seen.last !== due.last) begin
          report_mismatch($sformatf(
            "got kind=%0b x=%h y=%h mask=%h last=%0b, want kind=%0b x=%h y=%h mask=%h last=%0b",
            seen.kind, seen.x, seen.y, seen.row_mask, seen.last,
            due.kind, due.x, due.y, due.row_mask, due.last));
        end
      end
    end
  end

  // Watchdog for a hung handshake or a lost result.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus planning. Every queued command also updates the planning copy of
  // the table, so later draws can be checked for reading only written state.
  // --------------------------------------------------------------------------
  function automatic glyph_cmd_t random_item();
    glyph_cmd_t c;
    c.command      = 2'($urandom);
    c.glyph_index  = 7'($urandom);
    c.glyph_width  = 6'($urandom);
    c.glyph_height = 6'($urandom);
    c.glyph_offset = 12'($urandom);
    c.font_address = 12'($urandom);
    c.font_byte    = 8'($urandom);
    c.char_code    = 8'($urandom);
    c.pos_x        = 16'($urandom);
    c.pos_y        = 16'($urandom);
    return c;
  endfunction

  function automatic void queue_cmd(input glyph_cmd_t c);
    if (c.command == CMD_LOAD_DESC && int'(c.glyph_index) < GLYPH_COUNT) begin
      plan_width[c.glyph_index]    = clamp_size(c.glyph_width, MAX_GLYPH_WIDTH);
      plan_height[c.glyph_index]   = clamp_size(c.glyph_height, MAX_GLYPH_HEIGHT);
      plan_offset[c.glyph_index]   = c.glyph_offset;
      plan_desc_set[c.glyph_index] = 1'b1;
    end else if (c.command == CMD_LOAD_BYTE) begin
      plan_byte_set[int'(c.font_address) % FONT_BYTES] = 1'b1;
    end
    pending_cmds.push_back(c);
    queued_count++;
  endfunction

  function automatic void queue_desc(input logic [6:0] idx, input logic [5:0] w,
                                     input logic [5:0] h, input logic [11:0] off);
    glyph_cmd_t c;
    c = random_item();
    c.command      = CMD_LOAD_DESC;
    c.glyph_index  = idx;
    c.glyph_width  = w;
    c.glyph_height = h;
    c.glyph_offset = off;
    queue_cmd(c);
  endfunction

  function automatic void queue_byte(input logic [11:0] addr, input logic [7:0] value);
    glyph_cmd_t c;
    c = random_item();
    c.command      = CMD_LOAD_BYTE;
    c.font_address = addr;
    c.font_byte    = value;
    queue_cmd(c);
  endfunction

  function automatic void queue_draw(input logic [7:0] code, input logic [15:0] x,
                                     input logic [15:0] y);
    glyph_cmd_t c;
    c = random_item();
    c.command   = CMD_DRAW;
    c.char_code = code;
    c.pos_x     = x;
    c.pos_y     = y;
    queue_cmd(c);
  endfunction

  // Coordinates lean toward the top of the 16-bit range to exercise wrap.
  function automatic logic [15:0] pick_coord();
    int p;
    p = $urandom_range(99);
    if (p < 15) return 16'($urandom_range(16'hFFFF, 16'hFFC0));
    if (p < 20) return 16'($urandom_range(3, 0));
    return 16'($urandom);
  endfunction

  // True when drawing the code reads only table entries and bytes that the
  // queued commands will have written by then.
  function automatic bit draw_is_safe(input logic [7:0] code);
    int idx;
    int nbytes;
    if (code == SPACE_CODE) return 1'b1;
    idx = glyph_slot(code);
    if (idx < 0) return 1'b1;
    if (!plan_desc_set[idx]) return 1'b0;
    nbytes = (int'(plan_width[idx]) + 7) / 8;
    for (int row = 0; row < int'(plan_height[idx]); row++) begin
      for (int j = 0; j < nbytes; j++) begin
        if (!plan_byte_set[glyph_byte_addr(plan_offset[idx], j, row, plan_width[idx])])
          return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Draw of an arbitrary code; unsafe picks are retried and finally replaced
  // by a space.
  function automatic void queue_random_draw();
    logic [7:0] code;
    int         tries;
    code  = ($urandom_range(9) == 0) ? SPACE_CODE : 8'($urandom);
    tries = 0;
    while (!draw_is_safe(code) && tries < 8) begin
      code = 8'($urandom);
      tries++;
    end
    if (!draw_is_safe(code)) code = SPACE_CODE;
    queue_draw(code, pick_coord(), pick_coord());
  endfunction

  // The well-formed sequence: a descriptor for a code in range, every byte
  // that glyph reads, and then a few draws of it. Most glyphs are small; a
  // few are wide or tall, which also covers the saturating sizes.
  function automatic void queue_glyph_run();
    int         lo;
    int         hi;
    int         size;
    int         idx;
    int         ndraws;
    logic [7:0] code;
    logic [5:0] w;
    logic [5:0] h;
    logic [11:0] off;
    lo = cur_first;
    hi = cur_last;
    if (hi > lo + GLYPH_COUNT - 1) hi = lo + GLYPH_COUNT - 1;
    if (lo > hi) begin
      queue_random_draw();
      return;
    end
    code = 8'($urandom_range(hi, lo));
    if (code == SPACE_CODE) begin
      queue_draw(code, pick_coord(), pick_coord());
      return;
    end
    size = $urandom_range(99);
    if (size < 80) begin
      w = 6'($urandom_range(12, 0));
      h = 6'($urandom_range(5, 0));
    end else if (size < 90) begin
      w = 6'($urandom_range(63, 25));
      h = 6'($urandom_range(3, 1));
    end else begin
      w = 6'($urandom_range(8, 0));
      h = 6'($urandom_range(63, 17));
    end
    off = ($urandom_range(9) == 0) ? 12'($urandom_range(4095, 4000)) : 12'($urandom);
    idx = glyph_slot(code);
    queue_desc(7'(idx), w, h, off);
    for (int row = 0; row < int'(plan_height[idx]); row++) begin
      for (int j = 0; j < (int'(plan_width[idx]) + 7) / 8; j++) begin
        queue_byte(12'(glyph_byte_addr(plan_offset[idx], j, row, plan_width[idx])),
                   8'($urandom));
      end
    end
    ndraws = $urandom_range(3, 1);
    for (int k = 0; k < ndraws; k++) queue_draw(code, pick_coord(), pick_coord());
  endfunction

  // Mostly glyph sequences, with stray loads, stray draws and the unused
  // command mixed in as noise.
  task automatic run_random(input int count);
    int         stop;
    int         pick;
    glyph_cmd_t c;
    stop = queued_count + count;
    while (queued_count < stop) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        queue_glyph_run();
      end else if (pick < 75) begin
        queue_random_draw();
      end else if (pick < 85) begin
        queue_byte(12'($urandom), 8'($urandom));
      end else if (pick < 93) begin
        queue_desc(7'($urandom), 6'($urandom), 6'($urandom), 12'($urandom));
      end else begin
        c = random_item();
        c.command = CMD_UNUSED;
        queue_cmd(c);
      end
    end
  endtask

  // Short directed list under the reset code range 32..126.
  task automatic run_directed();
    glyph_cmd_t c;
    // Space with the advance wrapping past 0xFFFF.
    queue_draw(SPACE_CODE, 16'hFFFE, 16'h1234);
    // Codes just below and above the range, and the top code.
    queue_draw(8'd31, 16'h0000, 16'h0000);
    queue_draw(8'd127, 16'hFFFF, 16'hFFFF);
    queue_draw(8'd255, 16'h8000, 16'h7FFF);
    // The unused command.
    c = random_item();
    c.command = CMD_UNUSED;
    queue_cmd(c);
    // Oversized width saturates to 32; the four bytes of the row wrap around
    // the end of font memory.
    queue_desc(7'd33, 6'd63, 6'd1, 12'd4094);
    queue_byte(12'd4094, 8'hFF);
    queue_byte(12'd4095, 8'h80);
    queue_byte(12'd0, 8'h01);
    queue_byte(12'd1, 8'hAA);
    queue_draw(8'd65, 16'hFFFF, 16'hFFFF);
    // Zero width: rows with an empty mask, lines wrapping at 16 bits.
    queue_desc(7'd34, 6'd0, 6'd3, 12'd0);
    queue_draw(8'd66, 16'h0010, 16'hFFFE);
    // Zero height: cursor only.
    queue_desc(7'd35, 6'd8, 6'd0, 12'd200);
    queue_draw(8'd67, 16'h0100, 16'h0200);
    // Oversized height saturates to 32 rows.
    queue_desc(7'd36, 6'd0, 6'd63, 12'hFFF);
    queue_draw(8'd68, 16'h1000, 16'hFFF0);
    // Top table index; not drawable under this range.
    queue_desc(7'd127, 6'd5, 6'd2, 12'd7);
    // Single pixel glyph on the last code of the range.
    queue_desc(7'd94, 6'd1, 6'd1, 12'd100);
    queue_byte(12'd100, 8'h80);
    queue_draw(8'd126, 16'h0000, 16'h0000);
  endtask

  // Register write through the configuration channel; only called while the
  // block is idle.
  task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_FIRST_CODE:  cur_first = value;
      CFG_LAST_CODE:   cur_last  = value;
      CFG_SPACE_WIDTH: cur_space = value;
      default: ;
    endcase
  endtask

  // Waits for every queued command to transfer and every expected result to
  // arrive. Loads give no result, so a few extra cycles let the last one
  // finish before any register write.
  task automatic wait_for_quiet();
    int waited;
    do @(posedge clk); while (pending_cmds.size() != 0 || start);
    waited = 0;
    while ((rows_and_cursors.size() != 0 || busy) && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (rows_and_cursors.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                rows_and_cursors.size()));
      rows_and_cursors.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence. The sender idles rarely at first, then often, then never:
  // 18 percent, 82 percent, none.
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    idle_pct = 18;
    run_directed();
    wait_for_quiet();

    // Widest possible range and the largest space advance.
    write_register(CFG_FIRST_CODE, 8'd0);
    write_register(CFG_LAST_CODE, 8'd255);
    write_register(CFG_SPACE_WIDTH, 8'd255);
    run_random(120);
    wait_for_quiet();

    idle_pct = 82;
    write_register(CFG_FIRST_CODE, 8'($urandom_range(64, 0)));
    write_register(CFG_LAST_CODE, 8'($urandom_range(255, 128)));
    write_register(CFG_SPACE_WIDTH, 8'($urandom));
    run_random(90);
    wait_for_quiet();

    // Upper half of the codes, so code 255 reaches the last table entry and
    // a space lies below the range; zero space advance.
    idle_pct = 0;
    write_register(CFG_FIRST_CODE, 8'd128);
    write_register(CFG_LAST_CODE, 8'd255);
    write_register(CFG_SPACE_WIDTH, 8'd0);
    run_random(100);
    wait_for_quiet();

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/bgr_pkg.sv
design/bgr_addr_reduce.sv
design/bitmap_glyph_renderer.sv
dv/tb_bitmap_glyph_renderer.sv
